// File: design/assert_macros.svh
// Assertion helpers for the Hall position monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/hpfm_pkg.sv
package hpfm_pkg;

    localparam int POS_W      = 32;
    localparam int LVL_W      = 3;
    localparam int BLANK_W    = 16;
    localparam int WIN_W      = 10;
    localparam int RUN_W      = 3;
    localparam int FLT_W      = 4;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [BLANK_W-1:0] BLANK_LIMIT    = 16'd60000;
    localparam logic [BLANK_W-1:0] BLANK_TICKS    = 16'd2000;
    localparam logic [WIN_W-1:0]   SAMPLE_A_TICK  = 10'd400;
    localparam logic [WIN_W-1:0]   SAMPLE_B_TICK  = 10'd800;
    localparam logic [RUN_W-1:0]   RUN_LIMIT      = 3'd5;
    localparam logic [RUN_W-1:0]   RUN_MAX        = 3'd7;

    localparam int FLT_ILLEGAL  = 0;
    localparam int FLT_REVERSE  = 1;
    localparam int FLT_TOO_MANY = 2;
    localparam int FLT_TOO_FEW  = 3;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_LOAD    = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_RESTART = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALL_COUNT    = 3'd0,
        CFG_SINGLE_DIR    = 3'd1,
        CFG_INVERT_DIR    = 3'd2,
        CFG_MONITOR_EN    = 3'd3,
        CFG_EXPECTED_DIR  = 3'd4,
        CFG_TOO_FEW_THR   = 3'd5,
        CFG_TOO_MANY_THR  = 3'd6
    } cfg_index_t;

    // Neighbours of a level state in the commutation order.
    typedef struct packed {
        logic             hit;
        logic [LVL_W-1:0] pred;
        logic [LVL_W-1:0] succ;
    } seq_nbr_t;

    // Two-sensor order: 0, 1, 3, 2
    function automatic seq_nbr_t seq2_nbr(input logic [1:0] cur);
        seq_nbr_t r;
        r.hit = 1'b1;
        case (cur)
            2'd0:    begin r.pred = 3'd2; r.succ = 3'd1; end
            2'd1:    begin r.pred = 3'd0; r.succ = 3'd3; end
            2'd3:    begin r.pred = 3'd1; r.succ = 3'd2; end
            default: begin r.pred = 3'd3; r.succ = 3'd0; end
        endcase
        return r;
    endfunction

    // Three-sensor order: 4, 6, 2, 3, 1, 5
    function automatic seq_nbr_t seq3_nbr(input logic [LVL_W-1:0] cur);
        seq_nbr_t r;
        r.hit = 1'b1;
        case (cur)
            3'd4:    begin r.pred = 3'd5; r.succ = 3'd6; end
            3'd6:    begin r.pred = 3'd4; r.succ = 3'd2; end
            3'd2:    begin r.pred = 3'd6; r.succ = 3'd3; end
            3'd3:    begin r.pred = 3'd2; r.succ = 3'd1; end
            3'd1:    begin r.pred = 3'd3; r.succ = 3'd5; end
            3'd5:    begin r.pred = 3'd1; r.succ = 3'd4; end
            default: begin r.hit = 1'b0; r.pred = 3'd0; r.succ = 3'd0; end
        endcase
        return r;
    endfunction

endpackage

// File: design/hall_position_fault_monitor_unit.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// input    | s_tvalid/s_tready  | s_tuser action, s_tdata levels + position
// result   | m_tvalid/m_tready  | m_tdata position, step, fault flags
// config   | cfg_we             | cfg_index, cfg_wdata
//
// One beat per cycle sustained while m_tready is high; the result beat reaches m_ through
// the input register, then the result register. All state updates in one pass.
// Synchronous active-low reset clears control and state; config goes to defaults.
// A stall on m_tready backs up through the input register; s_tready drops only
// when both registers are full and m_tready is low.
`include "assert_macros.svh"

module hall_position_fault_monitor_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] hall_levels, [34:3] position_value, [39:35] zero
    input  logic [hpfm_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] position, [33:32] step_taken, [37:34] fault_flags, [39:38] zero
    output logic [hpfm_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [hpfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpfm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import hpfm_pkg::*;

    // config
    logic [1:0]        hall_count_reg;
    logic              single_dir_reg;
    logic              invert_dir_reg;
    logic              monitor_en_reg;
    logic              expected_dir_reg;
    logic [THR_W-1:0]  too_few_reg;
    logic [THR_W-1:0]  too_many_reg;

    // input stage
    logic              in_valid_reg;
    action_t           in_action_reg;
    logic [LVL_W-1:0]  in_levels_reg;
    logic [POS_W-1:0]  in_pos_reg;

    // block state
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [LVL_W-1:0]   prev_reg,  prev_next;
    logic [BLANK_W-1:0] blank_reg, blank_next;
    logic [WIN_W-1:0]   win_reg,   win_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [RUN_W-1:0]   run_reg,   run_next;
    logic [FLT_W-1:0]   fault_reg, fault_next;

    // result stage
    logic              m_valid_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [1:0]        m_step_reg;
    logic [FLT_W-1:0]  m_fault_reg;

    logic              out_free;
    logic              move;

    assign out_free = !m_valid_reg || m_tready;
    assign move     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hall_count_reg   <= 2'd3;
            single_dir_reg   <= 1'b0;
            invert_dir_reg   <= 1'b0;
            monitor_en_reg   <= 1'b0;
            expected_dir_reg <= 1'b1;
            too_few_reg      <= '0;
            too_many_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HALL_COUNT:   hall_count_reg   <= cfg_wdata[1:0];
                CFG_SINGLE_DIR:   single_dir_reg   <= cfg_wdata[0];
                CFG_INVERT_DIR:   invert_dir_reg   <= cfg_wdata[0];
                CFG_MONITOR_EN:   monitor_en_reg   <= cfg_wdata[0];
                CFG_EXPECTED_DIR: expected_dir_reg <= cfg_wdata[0];
                CFG_TOO_FEW_THR:  too_few_reg      <= cfg_wdata[THR_W-1:0];
                CFG_TOO_MANY_THR: too_many_reg     <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_levels_reg <= s_tdata[LVL_W-1:0];
            in_pos_reg    <= s_tdata[LVL_W+POS_W-1:LVL_W];
        end
    end

    // step decode
    logic [1:0]        sensors;
    logic [LVL_W-1:0]  cur;
    seq_nbr_t          nbr;
    logic              raw_up, raw_dn, up, dn;
    logic [POS_W-1:0]  pos_step;
    logic [1:0]        tick_step;

    always_comb begin
        sensors = (hall_count_reg == 2'd0) ? 2'd1 : hall_count_reg;
        case (sensors)
            2'd1:    cur = {2'b00, in_levels_reg[0]};
            2'd2:    cur = {1'b0, in_levels_reg[1:0]};
            default: cur = in_levels_reg;
        endcase
        nbr = (sensors == 2'd2) ? seq2_nbr(cur[1:0]) : seq3_nbr(cur);
        if (sensors == 2'd1) begin
            raw_up = (cur != prev_reg) && single_dir_reg;
            raw_dn = (cur != prev_reg) && !single_dir_reg;
        end else begin
            raw_up = nbr.hit && (prev_reg == nbr.pred);
            raw_dn = nbr.hit && (prev_reg == nbr.succ);
        end
        up = invert_dir_reg ? raw_dn : raw_up;
        dn = invert_dir_reg ? raw_up : raw_dn;
        if (up) begin
            pos_step  = pos_reg + POS_W'(1);
            tick_step = 2'b01;
        end else if (dn) begin
            pos_step  = pos_reg - POS_W'(1);
            tick_step = 2'b11;
        end else begin
            pos_step  = pos_reg;
            tick_step = 2'b00;
        end
    end

    // monitor
    logic [BLANK_W-1:0] blank_inc;
    logic [WIN_W-1:0]   win_inc;
    logic               legal;
    logic [RUN_W-1:0]   run_inc;
    logic               sample_a, sample_b;
    logic [POS_W-1:0]   diff, ndiff, mag;
    logic               neg, reverse;
    logic [FLT_W-1:0]   mon_fault;

    always_comb begin
        blank_inc = (blank_reg < BLANK_LIMIT) ? blank_reg + BLANK_W'(1) : blank_reg;
        win_inc   = (blank_inc >= BLANK_TICKS) ? win_reg + WIN_W'(1) : win_reg;
        legal     = (sensors != 2'd3) || ((cur != 3'd0) && (cur != 3'd7));
        if (legal) begin
            run_inc = '0;
        end else begin
            run_inc = (run_reg < RUN_MAX) ? run_reg + RUN_W'(1) : run_reg;
        end
        sample_a  = (win_inc == SAMPLE_A_TICK);
        sample_b  = (win_inc == SAMPLE_B_TICK);
        diff      = pos_step - start_reg;
        ndiff     = start_reg - pos_step;
        neg       = diff[POS_W-1];
        mag       = neg ? ndiff : diff;
        reverse   = expected_dir_reg ? neg : (!neg && (diff != '0));
        mon_fault = fault_reg;
        if (!legal && (run_inc >= RUN_LIMIT)) begin
            mon_fault[FLT_ILLEGAL] = 1'b1;
        end
        if (sample_b) begin
            if (reverse) begin
                mon_fault[FLT_REVERSE] = 1'b1;
            end
            if (mag > {{(POS_W-THR_W){1'b0}}, too_many_reg}) begin
                mon_fault[FLT_TOO_MANY] = 1'b1;
            end
            if (mag < {{(POS_W-THR_W){1'b0}}, too_few_reg}) begin
                mon_fault[FLT_TOO_FEW] = 1'b1;
            end
        end
    end

    logic [1:0] step_next;

    always_comb begin
        pos_next   = pos_reg;
        prev_next  = prev_reg;
        blank_next = blank_reg;
        win_next   = win_reg;
        start_next = start_reg;
        run_next   = run_reg;
        fault_next = fault_reg;
        step_next  = 2'b00;
        unique case (in_action_reg)
            ACT_TICK: begin
                pos_next  = pos_step;
                prev_next = cur;
                step_next = tick_step;
                if (monitor_en_reg) begin
                    blank_next = blank_inc;
                    win_next   = sample_b ? '0 : win_inc;
                    run_next   = run_inc;
                    fault_next = mon_fault;
                    if (sample_a) begin
                        start_next = pos_step;
                    end
                end
            end
            ACT_LOAD: begin
                pos_next = in_pos_reg;
            end
            ACT_CLEAR: begin
                fault_next = '0;
            end
            ACT_RESTART: begin
                blank_next = '0;
                win_next   = '0;
                run_next   = '0;
                fault_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            prev_reg  <= '0;
            blank_reg <= '0;
            win_reg   <= '0;
            start_reg <= '0;
            run_reg   <= '0;
            fault_reg <= '0;
        end else if (move) begin
            pos_reg   <= pos_next;
            prev_reg  <= prev_next;
            blank_reg <= blank_next;
            win_reg   <= win_next;
            start_reg <= start_next;
            run_reg   <= run_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            m_pos_reg   <= pos_next;
            m_step_reg  <= step_next;
            m_fault_reg <= fault_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-POS_W-2-FLT_W){1'b0}}, m_fault_reg, m_step_reg, m_pos_reg};

    `ASSERT_IMPLIES(a_stall_full, aclk, aresetn, !s_tready, in_valid_reg && m_valid_reg)
    `ASSERT_IMPLIES(a_blank_sat, aclk, aresetn, 1'b1, blank_reg <= BLANK_LIMIT)
    `ASSERT_IMPLIES(a_win_range, aclk, aresetn, 1'b1, win_reg < SAMPLE_B_TICK)
    `ASSERT_IMPLIES(a_fault_sticky, aclk, aresetn,
        move && (in_action_reg == ACT_TICK || in_action_reg == ACT_LOAD),
        (fault_reg & ~fault_next) == '0)
    `ASSERT_NEXT(a_restart_clears, aclk, aresetn, move && in_action_reg == ACT_RESTART,
        blank_reg == '0 && win_reg == '0 && fault_reg == '0)

endmodule
